>>> rtl/fra_pkg.sv
// fra_pkg: shared types and constants of the fraction arithmetic reducer
// action codes, controller states, command and status structs
// no dependencies
package fra_pkg;

   localparam int OPERAND_BITS_DEFAULT = 16;
   localparam int ACTION_BITS          = 3;
   localparam int NUM_OUT_BITS         = 33;
   localparam int DEN_OUT_BITS         = 32;

   localparam logic [ACTION_BITS-1:0] ACT_ADD      = 3'd0;
   localparam logic [ACTION_BITS-1:0] ACT_SUBTRACT = 3'd1;
   localparam logic [ACTION_BITS-1:0] ACT_MULTIPLY = 3'd2;
   localparam logic [ACTION_BITS-1:0] ACT_DIVIDE   = 3'd3;
   localparam logic [ACTION_BITS-1:0] ACT_SIMPLIFY = 3'd4;

   typedef enum logic [1:0] {
      MUL_NUM,
      MUL_CROSS,
      MUL_DEN
   } mul_sel_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_NUM,
      ST_MUL_CROSS,
      ST_MUL_DEN,
      ST_FORM,
      ST_CHECK,
      ST_GCD,
      ST_DIVIDE,
      ST_FINISH
   } ctrl_state_type;

   typedef struct packed {
      logic        capture;
      logic        mul_en;
      mul_sel_type mul_sel;
      logic        form;
      logic        gcd_init;
      logic        gcd_step;
      logic        div_init;
      logic        div_step;
      logic        out_load;
   } fra_cmd_type;

   typedef struct packed {
      logic reduce_needed;
      logic gcd_done;
      logic div_done;
      logic out_busy;
   } fra_status_type;

endpackage

>>> rtl/fra_ctrl.sv
// fra_ctrl: sequencer of the fraction arithmetic reducer
// steps multiplies, sum, gcd and divide; depends on fra_pkg
module fra_ctrl
   import fra_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_stall,
   input  fra_status_type status,
   output fra_cmd_type    cmd
);

   ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_sel = MUL_NUM;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MUL_NUM;
            end
         end
         ST_MUL_NUM: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_NUM;
            state_in    = ST_MUL_CROSS;
         end
         ST_MUL_CROSS: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_CROSS;
            state_in    = ST_MUL_DEN;
         end
         ST_MUL_DEN: begin
            cmd.mul_en  = 1'b1;
            cmd.mul_sel = MUL_DEN;
            state_in    = ST_FORM;
         end
         ST_FORM: begin
            cmd.form = 1'b1;
            state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (status.reduce_needed) begin
               cmd.gcd_init = 1'b1;
               state_in     = ST_GCD;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_GCD: begin
            if (status.gcd_done) begin
               cmd.div_init = 1'b1;
               state_in     = ST_DIVIDE;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FINISH: begin
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

>>> rtl/fra_datapath.sv
// fra_datapath: operand registers, shared multiplier, binary gcd, dividers
// and response register; depends on fra_pkg, driven by fra_ctrl
module fra_datapath
   import fra_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  fra_cmd_type                    cmd,
   output fra_status_type                 status,
   input  logic [ACTION_BITS-1:0]         req_action,
   input  logic signed [OPERAND_BITS-1:0] req_lhs_num,
   input  logic signed [OPERAND_BITS-1:0] req_lhs_den,
   input  logic signed [OPERAND_BITS-1:0] req_rhs_num,
   input  logic signed [OPERAND_BITS-1:0] req_rhs_den,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [NUM_OUT_BITS-1:0] rsp_result_num,
   output logic signed [DEN_OUT_BITS-1:0] rsp_result_den
);

   localparam int PW = 2 * OPERAND_BITS;
   // sums keep a carry bit while products are under 64 bits wide, else they wrap
   localparam int NW = (PW < 64) ? PW + 1 : PW;
   localparam int KW = $clog2(NW + 1);
   localparam int CW = $clog2(NW + 1);

   logic [ACTION_BITS-1:0]         act_ff;
   logic signed [OPERAND_BITS-1:0] a_ff, b_ff, c_ff, d_ff;
   logic signed [PW-1:0]           p0_ff, p1_ff, p2_ff;
   logic signed [NW-1:0]           num_ff, num_in;
   logic signed [PW-1:0]           den_ff, den_in;
   logic                           reduce_ff;
   logic [NW-1:0]                  u_ff, v_ff, u_in, v_in;
   logic [KW-1:0]                  k_ff, k_in;
   logic [NW-1:0]                  g_ff;
   logic [NW-1:0]                  qn_ff, qd_ff, rn_ff, rd_ff;
   logic [NW-1:0]                  qn_in, qd_in, rn_in, rd_in;
   logic [CW-1:0]                  cnt_ff;
   logic                           rsp_valid_ff;
   logic signed [NUM_OUT_BITS-1:0] rsp_num_ff;
   logic signed [DEN_OUT_BITS-1:0] rsp_den_ff;

   logic signed [OPERAND_BITS-1:0] mul_x, mul_y;
   logic signed [PW-1:0]           product;
   logic [NW-1:0]                  num_mag;
   logic [NW-1:0]                  den_ext;
   logic [NW-1:0]                  diff_uv, diff_vu;
   logic [NW:0]                    trial_n, trial_d;
   logic signed [NW-1:0]           fin_num, fin_den;
   logic signed [NW+NUM_OUT_BITS-1:0] num_wide;
   logic signed [NW+DEN_OUT_BITS-1:0] den_wide;

   // shared multiplier
   always_comb begin
      mul_x = a_ff;
      mul_y = d_ff;
      case (cmd.mul_sel)
         MUL_NUM: begin
            mul_x = a_ff;
            mul_y = (act_ff == ACT_MULTIPLY) ? c_ff : d_ff;
         end
         MUL_CROSS: begin
            mul_x = c_ff;
            mul_y = b_ff;
         end
         MUL_DEN: begin
            mul_x = b_ff;
            mul_y = (act_ff == ACT_DIVIDE) ? c_ff : d_ff;
         end
         default: begin
            mul_x = a_ff;
            mul_y = d_ff;
         end
      endcase
      product = mul_x * mul_y;
   end

   // unreduced result
   always_comb begin
      case (act_ff)
         ACT_ADD: begin
            num_in = NW'(p0_ff) + NW'(p1_ff);
            den_in = p2_ff;
         end
         ACT_SUBTRACT: begin
            num_in = NW'(p0_ff) - NW'(p1_ff);
            den_in = p2_ff;
         end
         ACT_MULTIPLY, ACT_DIVIDE: begin
            num_in = NW'(p0_ff);
            den_in = p2_ff;
         end
         ACT_SIMPLIFY: begin
            num_in = NW'(a_ff);
            den_in = PW'(b_ff);
         end
         default: begin
            num_in = '0;
            den_in = PW'(1);
         end
      endcase
   end

   assign num_mag = num_ff[NW-1] ? NW'(-num_ff) : num_ff;
   assign den_ext = NW'($unsigned(den_ff));

   // binary gcd step
   assign diff_uv = u_ff - v_ff;
   assign diff_vu = v_ff - u_ff;

   always_comb begin
      u_in = u_ff;
      v_in = v_ff;
      k_in = k_ff;
      if (!u_ff[0] && !v_ff[0]) begin
         u_in = u_ff >> 1;
         v_in = v_ff >> 1;
         k_in = k_ff + KW'(1);
      end else if (!u_ff[0]) begin
         u_in = u_ff >> 1;
      end else if (!v_ff[0]) begin
         v_in = v_ff >> 1;
      end else if (u_ff >= v_ff) begin
         u_in = diff_uv >> 1;
      end else begin
         v_in = diff_vu >> 1;
      end
   end

   // restoring division of numerator and denominator by the gcd
   assign trial_n = {rn_ff, qn_ff[NW-1]} - {1'b0, g_ff};
   assign trial_d = {rd_ff, qd_ff[NW-1]} - {1'b0, g_ff};

   always_comb begin
      if (!trial_n[NW]) begin
         rn_in = trial_n[NW-1:0];
         qn_in = {qn_ff[NW-2:0], 1'b1};
      end else begin
         rn_in = {rn_ff[NW-2:0], qn_ff[NW-1]};
         qn_in = {qn_ff[NW-2:0], 1'b0};
      end
      if (!trial_d[NW]) begin
         rd_in = trial_d[NW-1:0];
         qd_in = {qd_ff[NW-2:0], 1'b1};
      end else begin
         rd_in = {rd_ff[NW-2:0], qd_ff[NW-1]};
         qd_in = {qd_ff[NW-2:0], 1'b0};
      end
   end

   // final result, resized to the response fields
   always_comb begin
      if (reduce_ff) begin
         fin_num = num_ff[NW-1] ? NW'(-qn_ff) : qn_ff;
         fin_den = qd_ff;
      end else begin
         fin_num = num_ff;
         fin_den = NW'(den_ff);
      end
      num_wide = (NW + NUM_OUT_BITS)'(fin_num);
      den_wide = (NW + DEN_OUT_BITS)'(fin_den);
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff <= req_action;
         a_ff   <= req_lhs_num;
         b_ff   <= req_lhs_den;
         c_ff   <= req_rhs_num;
         d_ff   <= req_rhs_den;
      end
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_NUM:   p0_ff <= product;
            MUL_CROSS: p1_ff <= product;
            MUL_DEN:   p2_ff <= product;
            default:   p0_ff <= product;
         endcase
      end
      if (cmd.form) begin
         num_ff <= num_in;
         den_ff <= den_in;
      end
      if (cmd.gcd_init) begin
         u_ff <= num_mag;
         v_ff <= den_ext;
         k_ff <= '0;
      end else if (cmd.gcd_step) begin
         u_ff <= u_in;
         v_ff <= v_in;
         k_ff <= k_in;
      end
      if (cmd.div_init) begin
         g_ff   <= (u_ff | v_ff) << k_ff;
         qn_ff  <= num_mag;
         qd_ff  <= den_ext;
         rn_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= CW'(NW);
      end else if (cmd.div_step) begin
         qn_ff  <= qn_in;
         qd_ff  <= qd_in;
         rn_ff  <= rn_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_ff - CW'(1);
      end
      if (cmd.out_load) begin
         rsp_num_ff <= num_wide[NUM_OUT_BITS-1:0];
         rsp_den_ff <= den_wide[DEN_OUT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         reduce_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.capture) begin
            reduce_ff <= 1'b0;
         end else if (cmd.gcd_init) begin
            reduce_ff <= 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.reduce_needed = !den_ff[PW-1] && (den_ff[PW-1:1] != '0);
   assign status.gcd_done      = (u_ff == '0) || (v_ff == '0);
   assign status.div_done      = (cnt_ff == '0);
   assign status.out_busy      = rsp_valid_ff && rsp_stall;

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_result_num = rsp_num_ff;
   assign rsp_result_den = rsp_den_ff;

endmodule

>>> rtl/fraction_arithmetic_reducer.sv
// fraction_arithmetic_reducer: top level, adds, subtracts, multiplies or divides two
// fractions or simplifies one, reduces by the gcd; uses fra_pkg, fra_ctrl, fra_datapath
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  action, lhs_num, lhs_den, rhs_num, rhs_den
//   rsp      out        rsp_valid/rsp_stall  result_num, result_den
//
// one request at a time; req_stall is low only while the sequencer is idle
// without reduction a request runs capture, three multiplies, form, check and finish;
// with reduction binary gcd steps follow the check, then one restoring divide step
// per numerator bit, before the finish loads the response register
// the response register lets the next request start while a response is stalled
// synchronous reset clears the sequencer and rsp_valid
module fraction_arithmetic_reducer
   import fra_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [ACTION_BITS-1:0]         req_action,
   input  logic signed [OPERAND_BITS-1:0] req_lhs_num,
   input  logic signed [OPERAND_BITS-1:0] req_lhs_den,
   input  logic signed [OPERAND_BITS-1:0] req_rhs_num,
   input  logic signed [OPERAND_BITS-1:0] req_rhs_den,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [NUM_OUT_BITS-1:0] rsp_result_num,
   output logic signed [DEN_OUT_BITS-1:0] rsp_result_den
);

   fra_cmd_type    cmd;
   fra_status_type status;

   fra_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   fra_datapath #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .req_action     (req_action),
      .req_lhs_num    (req_lhs_num),
      .req_lhs_den    (req_lhs_den),
      .req_rhs_num    (req_rhs_num),
      .req_rhs_den    (req_rhs_den),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_result_num (rsp_result_num),
      .rsp_result_den (rsp_result_den)
   );

endmodule

>>> rtl/fra_checker.sv
// fra_checker: port-level assertions for the fraction arithmetic reducer
// bound to the top level; depends on fra_pkg
module fra_checker
   import fra_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEFAULT
)
(
   input logic                           clock,
   input logic                           reset,
   input logic                           req_valid,
   input logic                           req_stall,
   input logic [ACTION_BITS-1:0]         req_action,
   input logic signed [OPERAND_BITS-1:0] req_lhs_num,
   input logic signed [OPERAND_BITS-1:0] req_lhs_den,
   input logic signed [OPERAND_BITS-1:0] req_rhs_num,
   input logic signed [OPERAND_BITS-1:0] req_rhs_den,
   input logic                           rsp_valid,
   input logic                           rsp_stall,
   input logic signed [NUM_OUT_BITS-1:0] rsp_result_num,
   input logic signed [DEN_OUT_BITS-1:0] rsp_result_den
);

   logic [1:0] pending_ff, pending_in;
   logic       req_take, rsp_take;

   assign req_take = req_valid && !req_stall;
   assign rsp_take = rsp_valid && !rsp_stall;

   always_comb begin
      pending_in = pending_ff;
      if (req_take && !rsp_take) begin
         pending_in = pending_ff + 2'd1;
      end else if (!req_take && rsp_take) begin
         pending_in = pending_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   // one request in flight at most, besides a stalled response
   assert property (@(posedge clock) disable iff (reset)
      pending_ff != 2'd3)
      else $error("more than two requests outstanding");

   // no response without an accepted request
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 2'd0)
      else $error("response without request");

   // the block stalls right after taking a request
   assert property (@(posedge clock) disable iff (reset)
      req_take |=> req_stall)
      else $error("request taken while busy");

   // stalled response holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_result_num)
         && $stable(rsp_result_den))
      else $error("stalled response changed");

endmodule

bind fraction_arithmetic_reducer fra_checker #(
   .OPERAND_BITS (OPERAND_BITS)
) u_fra_checker (.*);
